/* hdl/hsteer_pkg.sv */
// ----------------------------------------------------------------------------
// Heading steering package
// Shared widths, fixed-point constants, CORDIC arctangent table and the word
// types passed between the front end, the word queue and the back end.
// ----------------------------------------------------------------------------
package hsteer_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 13;

    localparam int POS_W  = 24;
    localparam int HEAD_W = 18;
    localparam int TIME_W = 16;
    localparam int RATE_W = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

    localparam int ACC_FRAC   = 30;
    localparam int ATAN_DEPTH = 24;
    localparam int XY_W       = POS_W + 4;
    localparam int ACC_W      = ACC_FRAC + 4;
    localparam int ANG_W      = ANGLE_FRAC_BITS + 3;
    localparam int ANG_SH     = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int DIFF_W     = ((ANG_W > HEAD_W) ? ANG_W : HEAD_W) + 1;
    localparam int WRAP_W     = DIFF_W + 3;
    localparam int PROD1_W    = DIFF_W + RATE_W + 1;
    localparam int PROD2_W    = PROD1_W + TIME_W + 1;
    localparam int PROD_SH    = 24;
    localparam int SUM_W      = ((PROD2_W - PROD_SH > HEAD_W) ? PROD2_W - PROD_SH : HEAD_W) + 1;

    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint PI_ANG     = (PI_Q30 + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
    localparam longint TWO_PI_ANG = (2 * PI_Q30 + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
    localparam longint HMAX_RAW   = (4 * PI_Q30) >>> ANG_SH;
    localparam longint HMAX_LIM   = 64'sd131071;
    localparam longint HMAX_ANG   = (HMAX_RAW > HMAX_LIM) ? HMAX_LIM : HMAX_RAW;

    localparam logic signed [DIFF_W-1:0] PI_D      = DIFF_W'(PI_ANG);
    localparam logic signed [DIFF_W-1:0] TWO_PI_D  = DIFF_W'(TWO_PI_ANG);
    localparam logic signed [DIFF_W-1:0] FOUR_PI_D = DIFF_W'(2 * TWO_PI_ANG);
    localparam logic signed [DIFF_W-1:0] SIX_PI_D  = DIFF_W'(3 * TWO_PI_ANG);
    localparam logic signed [WRAP_W-1:0] PI_X1     = WRAP_W'(PI_ANG);
    localparam logic signed [WRAP_W-1:0] PI_X3     = WRAP_W'(PI_ANG + TWO_PI_ANG);
    localparam logic signed [WRAP_W-1:0] PI_X5     = WRAP_W'(PI_ANG + 2 * TWO_PI_ANG);
    localparam logic signed [SUM_W-1:0]  HMAX_S   = SUM_W'(HMAX_ANG);
    localparam logic signed [HEAD_W-1:0] HMAX_H   = HEAD_W'(HMAX_ANG);
    localparam logic signed [ACC_W-1:0]  HALF_PI_ACC = ACC_W'(PI_Q30 / 2);

    localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = $clog2(MQ_DEPTH);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic                     tgt;
        logic                     zero;
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [ACC_W-1:0]  acc;
        logic signed [HEAD_W-1:0] head;
        logic [TIME_W-1:0]        tstep;
    } hs_word_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic                     clipped;
    } hs_result_t;

endpackage

/* hdl/hsteer_front.sv */
// ----------------------------------------------------------------------------
// Heading steering front end
// Accepts input words, forms the target offset and the CORDIC start vector
// with its quadrant pre-rotation, and hands the word to the word queue.
// ----------------------------------------------------------------------------
module hsteer_front
    import hsteer_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     target_valid,
    input  logic signed [POS_W-1:0]  target_x,
    input  logic signed [POS_W-1:0]  target_z,
    input  logic signed [POS_W-1:0]  own_x,
    input  logic signed [POS_W-1:0]  own_z,
    input  logic signed [HEAD_W-1:0] current_heading,
    input  logic [TIME_W-1:0]        time_step,
    output logic                     word_push,
    output hs_word_t                 word,
    input  logic                     word_full
);

    logic                   f_valid_reg;
    logic                   f_valid_next;
    hs_word_t               f_word_reg;
    hs_word_t               f_word_next;
    logic                   take;
    logic signed [POS_W:0]  dx;
    logic signed [POS_W:0]  dz;
    logic signed [XY_W-1:0] xe;
    logic signed [XY_W-1:0] ye;

    assign full      = f_valid_reg && word_full;
    assign take      = push && !full;
    assign word_push = f_valid_reg && !word_full;
    assign word      = f_word_reg;

    always_comb
    begin
        dx = {target_x[POS_W-1], target_x} - {own_x[POS_W-1], own_x};
        dz = {target_z[POS_W-1], target_z} - {own_z[POS_W-1], own_z};
        xe = XY_W'(dz);
        ye = XY_W'(dx);
        f_word_next.tgt   = target_valid;
        f_word_next.zero  = (dx == '0) && (dz == '0);
        f_word_next.head  = current_heading;
        f_word_next.tstep = time_step;
        priority if (xe < 0 && ye >= 0)
        begin
            f_word_next.x   = ye;
            f_word_next.y   = -xe;
            f_word_next.acc = HALF_PI_ACC;
        end
        else if (xe < 0)
        begin
            f_word_next.x   = -ye;
            f_word_next.y   = xe;
            f_word_next.acc = -HALF_PI_ACC;
        end
        else
        begin
            f_word_next.x   = xe;
            f_word_next.y   = ye;
            f_word_next.acc = '0;
        end
    end

    always_comb
    begin
        priority if (take)
            f_valid_next = 1'b1;
        else if (word_push)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            f_word_reg <= f_word_next;
    end

endmodule

/* hdl/hsteer_queue.sv */
// ----------------------------------------------------------------------------
// Heading steering word queue
// Short first-in first-out buffer that decouples the front end from the
// back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module hsteer_queue
    import hsteer_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  hs_word_t wr_word,
    output logic     full,
    input  logic     rd_en,
    output hs_word_t rd_word,
    output logic     empty
);

    hs_word_t         mem_reg [MQ_DEPTH];
    logic [MQ_AW-1:0] wr_ptr_reg;
    logic [MQ_AW-1:0] wr_ptr_next;
    logic [MQ_AW-1:0] rd_ptr_reg;
    logic [MQ_AW-1:0] rd_ptr_next;
    logic [MQ_AW:0]   count_reg;
    logic [MQ_AW:0]   count_next;

    assign full    = (count_reg == (MQ_AW+1)'(MQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

endmodule

/* hdl/hsteer_back.sv */
// ----------------------------------------------------------------------------
// Heading steering back end
// Pipelined vectoring CORDIC for the bearing, heading error wrap, two-step
// gain multiply, rounding and saturation. The whole pipeline holds when its
// last stage cannot hand its word to the result queue.
// ----------------------------------------------------------------------------
module hsteer_back
    import hsteer_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RATE_W-1:0] turn_rate,
    input  logic              q_empty,
    input  hs_word_t          q_word,
    output logic              q_pop,
    output logic              res_push,
    output hs_result_t        res,
    input  logic              res_full
);

    logic                     adv;

    hs_word_t                 cw_reg [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] cv_reg;

    logic                     r_valid_reg;
    logic signed [DIFF_W-1:0] r_diff_reg;
    logic signed [DIFF_W-1:0] r_diff_next;
    logic signed [HEAD_W-1:0] r_head_reg;
    logic [TIME_W-1:0]        r_tstep_reg;
    logic signed [ANG_W-1:0]  ang;

    logic                     w_valid_reg;
    logic signed [DIFF_W-1:0] w_diff_reg;
    logic signed [DIFF_W-1:0] w_diff_next;
    logic signed [WRAP_W-1:0] w_diff_ext;
    logic signed [HEAD_W-1:0] w_head_reg;
    logic [TIME_W-1:0]        w_tstep_reg;

    logic                      m1_valid_reg;
    logic signed [PROD1_W-1:0] m1_prod_reg;
    logic signed [PROD1_W-1:0] m1_prod_next;
    logic signed [HEAD_W-1:0]  m1_head_reg;
    logic [TIME_W-1:0]         m1_tstep_reg;

    logic                      m2_valid_reg;
    logic signed [PROD2_W-1:0] m2_prod_reg;
    logic signed [PROD2_W-1:0] m2_prod_next;
    logic signed [HEAD_W-1:0]  m2_head_reg;

    logic                      fin_valid_reg;
    hs_result_t                fin_res_reg;
    hs_result_t                fin_res_next;
    logic signed [SUM_W-1:0]   rnd;
    logic signed [SUM_W-1:0]   sum;

    assign adv      = !(fin_valid_reg && res_full);
    assign q_pop    = adv && !q_empty;
    assign res_push = fin_valid_reg && !res_full;
    assign res      = fin_res_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        hs_word_t src;
        logic     src_v;
        hs_word_t stage_next;

        if (i == 0)
        begin : g_first
            assign src   = q_word;
            assign src_v = !q_empty;
        end
        else
        begin : g_rest
            assign src   = cw_reg[i-1];
            assign src_v = cv_reg[i-1];
        end

        always_comb
        begin
            logic signed [XY_W-1:0]  sx;
            logic signed [XY_W-1:0]  sy;
            logic signed [ACC_W-1:0] at;
            sx = src.x >>> i;
            sy = src.y >>> i;
            at = ACC_W'(ATAN_TAB[i]);
            stage_next = src;
            if (src.y >= 0)
            begin
                stage_next.x   = src.x + sy;
                stage_next.y   = src.y - sx;
                stage_next.acc = src.acc + at;
            end
            else
            begin
                stage_next.x   = src.x - sy;
                stage_next.y   = src.y + sx;
                stage_next.acc = src.acc - at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i] <= 1'b0;
            else if (adv)
                cv_reg[i] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                cw_reg[i] <= stage_next;
        end
    end

    // round bearing, form heading error
    always_comb
    begin
        ang = ANG_W'((cw_reg[CORDIC_STAGES-1].acc + ACC_W'(1 <<< (ANG_SH - 1))) >>> ANG_SH);
        if (cw_reg[CORDIC_STAGES-1].zero)
            ang = '0;
        if (cw_reg[CORDIC_STAGES-1].tgt)
            r_diff_next = DIFF_W'(ang) - DIFF_W'(cw_reg[CORDIC_STAGES-1].head);
        else
            r_diff_next = '0;
    end

    // wrap error into plus or minus pi
    always_comb
    begin
        w_diff_ext = WRAP_W'(r_diff_reg);
        priority if (w_diff_ext > PI_X5)
            w_diff_next = r_diff_reg - SIX_PI_D;
        else if (w_diff_ext > PI_X3)
            w_diff_next = r_diff_reg - FOUR_PI_D;
        else if (w_diff_ext > PI_X1)
            w_diff_next = r_diff_reg - TWO_PI_D;
        else if (w_diff_ext < -PI_X5)
            w_diff_next = r_diff_reg + SIX_PI_D;
        else if (w_diff_ext < -PI_X3)
            w_diff_next = r_diff_reg + FOUR_PI_D;
        else if (w_diff_ext < -PI_X1)
            w_diff_next = r_diff_reg + TWO_PI_D;
        else
            w_diff_next = r_diff_reg;
    end

    assign m1_prod_next = PROD1_W'(w_diff_reg) * PROD1_W'($signed({1'b0, turn_rate}));
    assign m2_prod_next = PROD2_W'(m1_prod_reg) * PROD2_W'($signed({1'b0, m1_tstep_reg}));

    // round product, add, saturate
    always_comb
    begin
        rnd = SUM_W'((m2_prod_reg + (PROD2_W'(1) <<< (PROD_SH - 1))) >>> PROD_SH);
        sum = rnd + SUM_W'(m2_head_reg);
        priority if (sum > HMAX_S)
        begin
            fin_res_next.heading = HMAX_H;
            fin_res_next.clipped = 1'b1;
        end
        else if (sum < -HMAX_S)
        begin
            fin_res_next.heading = -HMAX_H;
            fin_res_next.clipped = 1'b1;
        end
        else
        begin
            fin_res_next.heading = HEAD_W'(sum);
            fin_res_next.clipped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg   <= cv_reg[CORDIC_STAGES-1];
            w_valid_reg   <= r_valid_reg;
            m1_valid_reg  <= w_valid_reg;
            m2_valid_reg  <= m1_valid_reg;
            fin_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_diff_reg   <= r_diff_next;
            r_head_reg   <= cw_reg[CORDIC_STAGES-1].head;
            r_tstep_reg  <= cw_reg[CORDIC_STAGES-1].tstep;
            w_diff_reg   <= w_diff_next;
            w_head_reg   <= r_head_reg;
            w_tstep_reg  <= r_tstep_reg;
            m1_prod_reg  <= m1_prod_next;
            m1_head_reg  <= w_head_reg;
            m1_tstep_reg <= w_tstep_reg;
            m2_prod_reg  <= m2_prod_next;
            m2_head_reg  <= m1_head_reg;
            fin_res_reg  <= fin_res_next;
        end
    end

endmodule

/* hdl/heading_steer_to_target.sv */
// ----------------------------------------------------------------------------
// Heading steering toward a target
// Top level: configuration register, front end, word queue, back end and
// result queue.
// ----------------------------------------------------------------------------
// The block takes one word per clock while full is low and returns one result
// word per input word, in order. A word passes from push to the result side
// through the front register, the word queue, a register for each of the
// CORDIC stages (16 by default), then rounding, error wrap, two multiply
// stages and saturation. With pop kept high the sustained rate is one word per
// cycle. turn_rate resets to 1.0 (Q8.8); the user must write it only while no
// word is in flight, and the block itself does not enforce this.
module heading_steer_to_target
    import hsteer_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [RATE_W-1:0]        cfg_data,
    input  logic                     push,
    output logic                     full,
    input  logic                     target_valid,
    input  logic signed [POS_W-1:0]  target_x,
    input  logic signed [POS_W-1:0]  target_z,
    input  logic signed [POS_W-1:0]  own_x,
    input  logic signed [POS_W-1:0]  own_z,
    input  logic signed [HEAD_W-1:0] current_heading,
    input  logic [TIME_W-1:0]        time_step,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [HEAD_W-1:0] new_heading,
    output logic                     heading_clipped
);

    logic [RATE_W-1:0] turn_rate_reg;
    logic [RATE_W-1:0] turn_rate_next;

    logic              mq_push;
    hs_word_t          mq_wr_word;
    logic              mq_full;
    logic              mq_pop;
    hs_word_t          mq_rd_word;
    logic              mq_empty;

    logic              res_push;
    hs_result_t        res;
    logic              oq_full;
    logic              oq_pop;
    hs_result_t        oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]  oq_wr_ptr_reg;
    logic [OQ_AW-1:0]  oq_wr_ptr_next;
    logic [OQ_AW-1:0]  oq_rd_ptr_reg;
    logic [OQ_AW-1:0]  oq_rd_ptr_next;
    logic [OQ_AW:0]    oq_count_reg;
    logic [OQ_AW:0]    oq_count_next;

    assign cfg_ready      = 1'b1;
    assign turn_rate_next = (cfg_valid && cfg_ready) ? cfg_data : turn_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            turn_rate_reg <= RATE_RESET;
        else
            turn_rate_reg <= turn_rate_next;
    end

    hsteer_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .target_valid    (target_valid),
        .target_x        (target_x),
        .target_z        (target_z),
        .own_x           (own_x),
        .own_z           (own_z),
        .current_heading (current_heading),
        .time_step       (time_step),
        .word_push       (mq_push),
        .word            (mq_wr_word),
        .word_full       (mq_full)
    );

    hsteer_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mq_push),
        .wr_word (mq_wr_word),
        .full    (mq_full),
        .rd_en   (mq_pop),
        .rd_word (mq_rd_word),
        .empty   (mq_empty)
    );

    hsteer_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .turn_rate (turn_rate_reg),
        .q_empty   (mq_empty),
        .q_word    (mq_rd_word),
        .q_pop     (mq_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (oq_full)
    );

    // result queue
    assign oq_full         = (oq_count_reg == (OQ_AW+1)'(OQ_DEPTH));
    assign empty           = (oq_count_reg == '0);
    assign oq_pop          = pop && !empty;
    assign new_heading     = oq_mem_reg[oq_rd_ptr_reg].heading;
    assign heading_clipped = oq_mem_reg[oq_rd_ptr_reg].clipped;

    always_comb
    begin
        oq_wr_ptr_next = res_push ? oq_wr_ptr_reg + 1'b1 : oq_wr_ptr_reg;
        oq_rd_ptr_next = oq_pop ? oq_rd_ptr_reg + 1'b1 : oq_rd_ptr_reg;
        unique case ({res_push, oq_pop})
            2'b10:   oq_count_next = oq_count_reg + 1'b1;
            2'b01:   oq_count_next = oq_count_reg - 1'b1;
            default: oq_count_next = oq_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            oq_mem_reg[oq_wr_ptr_reg] <= res;
    end

    a_heading_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (new_heading <= HMAX_H && new_heading >= -HMAX_H)
    ) else $error("result heading outside saturation range");

    a_clip_at_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && heading_clipped) |-> (new_heading == HMAX_H || new_heading == -HMAX_H)
    ) else $error("clipped result not at a range bound");

    a_no_result_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        (oq_full && !oq_pop) |=> !$past(res_push)
    ) else $error("back end pushed into a full result queue");

endmodule

/* tb/sv/heading_steer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heading steering checker
// Watches the configuration, input and result channels of the steering block.
// Each accepted input word is turned into the expected heading and clip flag,
// which are held in order. Each accepted result word is compared with the
// oldest of them. Failures are counted and passed to the testbench top.
// ----------------------------------------------------------------------------
module heading_steer_checker
    import hsteer_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [RATE_W-1:0]        cfg_data,
    input  logic                     push,
    input  logic                     full,
    input  logic                     target_valid,
    input  logic signed [POS_W-1:0]  target_x,
    input  logic signed [POS_W-1:0]  target_z,
    input  logic signed [POS_W-1:0]  own_x,
    input  logic signed [POS_W-1:0]  own_z,
    input  logic signed [HEAD_W-1:0] current_heading,
    input  logic [TIME_W-1:0]        time_step,
    input  logic                     empty,
    input  logic                     pop,
    input  logic signed [HEAD_W-1:0] new_heading,
    input  logic                     heading_clipped,
    output int                       errors,
    output int                       pending,
    output int                       results,
    output int                       saturated
);

    localparam longint Q30_PI    = 64'sd3373259426;
    localparam int     Q30_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam longint ANG_PI    = (Q30_PI + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
    localparam longint ANG_2PI   = (2 * Q30_PI + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
    localparam longint LIM_RAW   = (4 * Q30_PI) >>> Q30_SHIFT;
    localparam longint HEAD_LIM  = (LIM_RAW > 64'sd131071) ? 64'sd131071 : LIM_RAW;
    localparam logic [RATE_W-1:0] GAIN_AT_RESET = 16'd256;

    localparam longint ATAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    logic [RATE_W-1:0] gain;
    hs_result_t        heading_due [$];

    function automatic longint target_bearing(input longint across, input longint ahead);
        longint x;
        longint y;
        longint acc;
        longint t;
        longint xs;
        longint ys;
        int     n;
        int     i;
        x   = ahead;
        y   = across;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t;
                acc = Q30_PI / 2;
            end
            else
            begin
                t = x; x = -y; y = t;
                acc = -(Q30_PI / 2);
            end
        end
        n = (CORDIC_STAGES > 24) ? 24 : ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);
        for (i = 0; i < n; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; acc += ATAN_Q30[i];
            end
            else
            begin
                x = x - ys; y = y + xs; acc -= ATAN_Q30[i];
            end
        end
        return (acc + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
    endfunction

    function automatic hs_result_t steer_predict(
        input logic                     tv,
        input logic signed [POS_W-1:0]  tx,
        input logic signed [POS_W-1:0]  tz,
        input logic signed [POS_W-1:0]  ox,
        input logic signed [POS_W-1:0]  oz,
        input logic signed [HEAD_W-1:0] hd,
        input logic [TIME_W-1:0]        ts,
        input logic [RATE_W-1:0]        g
    );
        hs_result_t r;
        longint     head;
        longint     res;
        longint     err;
        longint     prod;
        longint     g64;
        longint     ts64;
        int         k;
        head = hd;
        g64  = g;
        ts64 = ts;
        res  = head;
        if (tv)
        begin
            err = target_bearing(longint'(tx) - longint'(ox), longint'(tz) - longint'(oz)) - head;
            for (k = 0; k < 3 && err > ANG_PI; k++)
                err -= ANG_2PI;
            for (k = 0; k < 3 && err < -ANG_PI; k++)
                err += ANG_2PI;
            prod = err * g64 * ts64;
            res  = head + ((prod + (64'sd1 <<< 23)) >>> 24);
        end
        r.clipped = 1'b0;
        if (res > HEAD_LIM)
        begin
            res = HEAD_LIM; r.clipped = 1'b1;
        end
        else if (res < -HEAD_LIM)
        begin
            res = -HEAD_LIM; r.clipped = 1'b1;
        end
        r.heading = res[HEAD_W-1:0];
        return r;
    endfunction

    task automatic flag_word(input string what, input hs_result_t want);
        errors++;
        if (errors <= 10)
            $display("%0t checker: %s: expected heading %0d clip %0b, got heading %0d clip %0b",
                     $time, what, want.heading, want.clipped, new_heading, heading_clipped);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hs_result_t want;
        if (!rst_n)
        begin
            gain = GAIN_AT_RESET;
            heading_due.delete();
            errors    = 0;
            results   = 0;
            saturated = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                results++;
                if (heading_clipped === 1'b1)
                    saturated++;
                if (heading_due.size() == 0)
                begin
                    want = '0;
                    flag_word("unexpected result word", want);
                end
                else
                begin
                    want = heading_due.pop_front();
                    if (want.heading !== new_heading || want.clipped !== heading_clipped)
                        flag_word("result mismatch", want);
                end
            end
            if (push && !full)
                heading_due.push_back(steer_predict(target_valid, target_x, target_z, own_x,
                                                    own_z, current_heading, time_step, gain));
            if (cfg_valid && cfg_ready)
                gain = cfg_data;
        end
        pending = heading_due.size();
    end

endmodule

/* tb/sv/tb_heading_steer_to_target.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heading steering testbench
// Drives directed and random steering words through the block under several
// turn_rate settings, with random gaps on both sides and one long result
// stall. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_heading_steer_to_target;
    import hsteer_pkg::*;

    localparam logic signed [HEAD_W-1:0] HEAD_LIM = 18'sd102943;
    localparam logic signed [HEAD_W-1:0] HEAD_TOP = 18'sh1FFFF;
    localparam logic signed [HEAD_W-1:0] HEAD_BOT = 18'sh20000;
    localparam logic signed [POS_W-1:0]  POS_TOP  = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0]  POS_BOT  = 24'sh800000;
    localparam int PHASE_WORDS = 100;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic                     tv;
        logic signed [POS_W-1:0]  tx;
        logic signed [POS_W-1:0]  tz;
        logic signed [POS_W-1:0]  ox;
        logic signed [POS_W-1:0]  oz;
        logic signed [HEAD_W-1:0] hd;
        logic [TIME_W-1:0]        ts;
    } steer_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [RATE_W-1:0]        cfg_data;
    logic                     push;
    logic                     full;
    logic                     target_valid;
    logic signed [POS_W-1:0]  target_x;
    logic signed [POS_W-1:0]  target_z;
    logic signed [POS_W-1:0]  own_x;
    logic signed [POS_W-1:0]  own_z;
    logic signed [HEAD_W-1:0] current_heading;
    logic [TIME_W-1:0]        time_step;
    logic                     empty;
    logic                     pop;
    logic signed [HEAD_W-1:0] new_heading;
    logic                     heading_clipped;

    int fail_count;
    int words_due;
    int results_seen;
    int saturated_seen;
    int words_sent;
    int untargeted;
    int gain_writes;
    bit quiet;
    bit held;

    heading_steer_to_target dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .target_valid    (target_valid),
        .target_x        (target_x),
        .target_z        (target_z),
        .own_x           (own_x),
        .own_z           (own_z),
        .current_heading (current_heading),
        .time_step       (time_step),
        .empty           (empty),
        .pop             (pop),
        .new_heading     (new_heading),
        .heading_clipped (heading_clipped)
    );

    heading_steer_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .target_valid    (target_valid),
        .target_x        (target_x),
        .target_z        (target_z),
        .own_x           (own_x),
        .own_z           (own_z),
        .current_heading (current_heading),
        .time_step       (time_step),
        .empty           (empty),
        .pop             (pop),
        .new_heading     (new_heading),
        .heading_clipped (heading_clipped),
        .errors          (fail_count),
        .pending         (words_due),
        .results         (results_seen),
        .saturated       (saturated_seen)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    function automatic steer_word_t mk(
        input logic                     tv,
        input logic signed [POS_W-1:0]  tx,
        input logic signed [POS_W-1:0]  tz,
        input logic signed [POS_W-1:0]  ox,
        input logic signed [POS_W-1:0]  oz,
        input logic signed [HEAD_W-1:0] hd,
        input logic [TIME_W-1:0]        ts
    );
        steer_word_t w;
        w.tv = tv; w.tx = tx; w.tz = tz; w.ox = ox; w.oz = oz; w.hd = hd; w.ts = ts;
        return w;
    endfunction

    function automatic logic signed [POS_W-1:0] pos_corner();
        case ($urandom_range(4))
            0:       return POS_TOP;
            1:       return POS_BOT;
            2:       return '0;
            3:       return -24'sd1;
            default: return 24'sd1;
        endcase
    endfunction

    function automatic steer_word_t random_word();
        steer_word_t             w;
        int                      kind;
        int                      sh;
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dz;
        kind = $urandom_range(99);
        w.tv = 1'b1;
        w.ox = 24'($urandom);
        w.oz = 24'($urandom);
        w.tx = 24'($urandom);
        w.tz = 24'($urandom);
        if (kind < 10)
            w.tv = 1'b0;
        else if (kind >= 30 && kind < 70)
        begin
            sh   = $urandom_range(23);
            dx   = 24'($urandom);
            dz   = 24'($urandom);
            w.tx = w.ox + (dx >>> sh);
            w.tz = w.oz + (dz >>> $urandom_range(23));
        end
        else if (kind >= 70 && kind < 80)
        begin
            case ($urandom_range(2))
                0:
                begin
                    w.tx = w.ox; w.tz = w.oz;
                end
                1:       w.tx = w.ox;
                default: w.tz = w.oz;
            endcase
        end
        else if (kind >= 80)
        begin
            w.tx = pos_corner(); w.tz = pos_corner();
            w.ox = pos_corner(); w.oz = pos_corner();
        end
        sh = $urandom_range(99);
        if (sh < 80)
            w.hd = 18'(int'($urandom_range(205886)) - 102943);
        else if (sh < 95)
            w.hd = 18'($urandom);
        else
        begin
            case ($urandom_range(3))
                0:       w.hd = HEAD_LIM;
                1:       w.hd = -HEAD_LIM;
                2:       w.hd = HEAD_TOP;
                default: w.hd = HEAD_BOT;
            endcase
        end
        sh = $urandom_range(99);
        if (sh < 60)
            w.ts = 16'($urandom);
        else if (sh < 80)
            w.ts = 16'($urandom_range(255));
        else if (sh < 90)
            w.ts = '0;
        else
            w.ts = '1;
        return w;
    endfunction

    task automatic offer_word(input steer_word_t w);
        if (!quiet && $urandom_range(99) < 6)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
        @(negedge clk);
        push            <= 1'b1;
        target_valid    <= w.tv;
        target_x        <= w.tx;
        target_z        <= w.tz;
        own_x           <= w.ox;
        own_z           <= w.oz;
        current_heading <= w.hd;
        time_step       <= w.ts;
        do
            @(posedge clk);
        while (full);
        words_sent++;
        if (!w.tv)
            untargeted++;
    endtask

    task automatic drain_then_set_gain(input logic [RATE_W-1:0] g);
        @(negedge clk);
        push <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_data  <= g;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gain_writes++;
    endtask

    // result side: random stalls, one long hold-off while words keep coming
    initial
    begin
        pop  = 1'b0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 140)
            begin
                held = 1'b1;
                pop <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(negedge clk);
            end
            else
                pop <= quiet || ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        logic [RATE_W-1:0] phase_gain [6];
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        push            = 1'b0;
        target_valid    = 1'b0;
        target_x        = '0;
        target_z        = '0;
        own_x           = '0;
        own_z           = '0;
        current_heading = '0;
        time_step       = '0;
        quiet           = 1'b0;
        words_sent      = 0;
        untargeted      = 0;
        gain_writes     = 0;
        phase_gain      = '{16'd256, 16'hFFFF, 16'd0, 16'($urandom), 16'd1, 16'($urandom)};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        offer_word(mk(0, 0, 0, 0, 0, 0, 16'd1000));
        offer_word(mk(0, 0, 0, 0, 0, HEAD_LIM, 16'hFFFF));
        offer_word(mk(0, 0, 0, 0, 0, HEAD_TOP, 16'hFFFF));
        offer_word(mk(0, 0, 0, 0, 0, HEAD_BOT, 16'd0));
        offer_word(mk(1, 5, 5, 5, 5, 0, 16'hFFFF));
        offer_word(mk(1, 100, -100, 100, -100, HEAD_LIM, 16'hFFFF));
        offer_word(mk(1, 0, 256000, 0, 0, 0, 16'hFFFF));
        offer_word(mk(1, 0, -256000, 0, 0, 0, 16'hFFFF));
        offer_word(mk(1, -300, -700, 0, 0, 0, 16'h8000));
        offer_word(mk(1, 300, -700, 0, 0, 0, 16'h8000));
        offer_word(mk(1, 5000, 0, 0, 0, 0, 16'hFFFF));
        offer_word(mk(1, -5000, 0, 0, 0, 0, 16'hFFFF));
        offer_word(mk(1, POS_TOP, POS_BOT, POS_BOT, POS_TOP, 0, 16'hFFFF));
        offer_word(mk(1, POS_BOT, POS_TOP, POS_TOP, POS_BOT, 0, 16'hFFFF));
        offer_word(mk(1, 0, 1000, 0, 0, -HEAD_LIM, 16'hFFFF));
        offer_word(mk(1, -10, -1000, 0, 0, HEAD_LIM, 16'hFFFF));
        offer_word(mk(1, 10, -1000, 0, 0, HEAD_BOT, 16'hFFFF));
        offer_word(mk(1, -10, -1000, 0, 0, HEAD_TOP, 16'hFFFF));
        offer_word(mk(1, 1000, 1000, 0, 0, 0, 16'd0));
        offer_word(mk(1, 0, -1000, 0, 0, -18'sd25736, 16'hFFFF));
        offer_word(mk(1, 1, 1, 0, 0, HEAD_LIM, 16'hFFFF));

        for (int p = 0; p < 6; p++)
        begin
            drain_then_set_gain(phase_gain[p]);
            quiet = (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++)
                offer_word(random_word());
            quiet = 1'b0;
        end

        @(negedge clk);
        push <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("tb_heading_steer_to_target: %0d words, %0d without a target, %0d turn_rate writes",
                 words_sent, untargeted, gain_writes);
        $display("tb_heading_steer_to_target: %0d results checked, %0d saturated, %0d failures",
                 results_seen, saturated_seen, fail_count);
        if (fail_count == 0 && words_due == 0)
            $display("tb_heading_steer_to_target: done, clean");
        else
            $display("tb_heading_steer_to_target: done, errors");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb_heading_steer_to_target: done, errors");
        $finish;
    end

endmodule
